FILE: hdl/tiew_pkg.sv
package tiew_pkg;

   localparam int ProgramDepth = 8;
   localparam int LoadStations = 3;
   localparam int AddStations = 3;
   localparam int MultStations = 2;
   localparam int AllStations = LoadStations + AddStations + MultStations;
   localparam int FpRegs = 16;

   localparam int PIdxW = $clog2(ProgramDepth);
   localparam int StW = $clog2(AllStations);
   localparam int RegW = $clog2(FpRegs);

   localparam logic [2:0] OP_LOAD = 3'd0;
   localparam logic [2:0] OP_ADD = 3'd1;
   localparam logic [2:0] OP_SUB = 3'd2;
   localparam logic [2:0] OP_MULT = 3'd3;
   localparam logic [2:0] OP_DIV = 3'd4;

   localparam logic [2:0] KIND_ISSUE = 3'd0;
   localparam logic [2:0] KIND_BEGIN = 3'd1;
   localparam logic [2:0] KIND_END = 3'd2;
   localparam logic [2:0] KIND_WB = 3'd3;
   localparam logic [2:0] KIND_STATUS = 3'd4;

   localparam logic [1:0] CSR_LOAD_LAT = 2'd0;
   localparam logic [1:0] CSR_ADD_LAT = 2'd1;
   localparam logic [1:0] CSR_MULT_LAT = 2'd2;
   localparam logic [1:0] CSR_DIV_LAT = 2'd3;

   typedef enum logic [2:0] {
      ST_UNISSUED = 3'd0,
      ST_WAITING = 3'd1,
      ST_RUNNING = 3'd2,
      ST_DONE_EXEC = 3'd3,
      ST_FINISHED = 3'd4
   } stage_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_EXEC,
      SEQ_RUN,
      SEQ_WB,
      SEQ_ISSUE,
      SEQ_STATUS
   } seq_state_type;

   typedef struct packed {
      logic       func;
      logic [2:0] opcode;
      logic [3:0] dest_reg;
      logic [3:0] src_a_reg;
      logic [3:0] src_b_reg;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  instr_index;
      logic [15:0] cycle;
      logic        accepted;
      logic        all_done;
      logic        last;
   } rsp_type;

endpackage

FILE: hdl/tomasulo_issue_exec_writeback.sv
// channel  | ports                          | direction | handshake
// request  | req_start, req_busy, req_data  | in        | start high while busy low
// response | rsp_strobe, rsp_data           | out       | single-cycle strobe per beat, no stall
// csr      | csr_valid/ready/index/wdata    | in        | valid and ready
// an append goes from idle straight to the status beat; a tick that is not finished
// makes three passes over the program store (execute, run, writeback), one entry per
// cycle except that a start whose latency runs out at once holds for its end beat, then issue and status.
// one beat leaves per cycle at most.
// reset clears the control state directly; no clearing pass.
// the receiver cannot stall; every beat is taken in the cycle it is shown.
module tomasulo_issue_exec_writeback
   import tiew_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_start,
   output logic          req_busy,
   input  req_type       req_data,
   output logic          rsp_strobe,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [7:0]    csr_wdata
);

   logic [7:0] lat_ff [4];
   logic [2:0] op_ff [ProgramDepth];
   logic [RegW-1:0] dst_ff [ProgramDepth];
   logic [RegW-1:0] sa_ff [ProgramDepth];
   logic [RegW-1:0] sb_ff [ProgramDepth];
   stage_type stage_ff [ProgramDepth];
   stage_type snap_ff [ProgramDepth];
   logic [7:0] rem_ff [ProgramDepth];
   logic [StW-1:0] tag_ff [ProgramDepth];
   logic [ProgramDepth-1:0] began_ff;
   logic [AllStations-1:0] sbusy_ff, wa_on_ff, wb_on_ff;
   logic [StW-1:0] wa_ff [AllStations];
   logic [StW-1:0] wb_ff [AllStations];
   logic [FpRegs-1:0] rpend_ff;
   logic [StW-1:0] rstat_ff [FpRegs];
   logic [PIdxW:0] count_ff;
   logic [15:0] cycle_ff;
   logic finished_ff, acc_ff;
   logic [PIdxW:0] ptr_ff, ptr_in;
   logic [PIdxW:0] first_ff;
   logic first_ok_ff;
   logic end_pend_ff;
   seq_state_type state_ff, state_in;

   logic [PIdxW-1:0] pi;
   logic at_end, take, busy_i;
   assign pi = ptr_ff[PIdxW-1:0];
   assign at_end = (ptr_ff == count_ff);
   assign take = req_start && !busy_i;
   assign req_busy = busy_i;
   assign busy_i = (state_ff != SEQ_IDLE);
   assign csr_ready = !busy_i;

   // per-entry combinational view for the current pass
   logic [StW-1:0] cur_tag;
   logic cur_blocked;
   logic [7:0] rem_dec;
   logic begin_end;
   assign cur_tag = tag_ff[pi];
   assign cur_blocked = (op_ff[pi] != OP_LOAD) && (wa_on_ff[cur_tag] || wb_on_ff[cur_tag]);
   assign rem_dec = (rem_ff[pi] != 8'd0) ? rem_ff[pi] - 8'd1 : 8'd0;
   // a start whose latency runs out at once needs a second beat for its end
   assign begin_end = !end_pend_ff && !at_end && snap_ff[pi] == ST_WAITING && !cur_blocked &&
                      !began_ff[pi] && rem_dec == 8'd0;

   // oldest unissued entry
   logic [PIdxW:0] first_c;
   logic first_ok_c;
   always_comb begin
      first_ok_c = 1'b0;
      first_c = '0;
      for (int i = ProgramDepth - 1; i >= 0; i--)
         if (i < int'(count_ff) && stage_ff[i] == ST_UNISSUED) begin
            first_ok_c = 1'b1;
            first_c = (PIdxW+1)'(i);
         end
   end

   // issue station search
   logic [2:0] iop;
   logic [StW-1:0] free_s;
   logic free_ok;
   logic [7:0] ilat_raw, ilat;
   assign iop = op_ff[first_ff[PIdxW-1:0]];
   always_comb begin
      free_ok = 1'b0;
      free_s = '0;
      for (int s = AllStations - 1; s >= 0; s--) begin
         if (!sbusy_ff[s]) begin
            if ((iop == OP_LOAD && s < LoadStations) ||
                ((iop == OP_ADD || iop == OP_SUB) && s >= LoadStations &&
                 s < LoadStations + AddStations) ||
                ((iop == OP_MULT || iop == OP_DIV) && s >= LoadStations + AddStations)) begin
               free_ok = 1'b1;
               free_s = StW'(s);
            end
         end
      end
      case (iop)
         OP_LOAD: ilat_raw = lat_ff[CSR_LOAD_LAT];
         OP_ADD, OP_SUB: ilat_raw = lat_ff[CSR_ADD_LAT];
         OP_MULT: ilat_raw = lat_ff[CSR_MULT_LAT];
         default: ilat_raw = lat_ff[CSR_DIV_LAT];
      endcase
      ilat = (ilat_raw == 8'd0) ? 8'd1 : ilat_raw;
   end

   logic all_fin;
   always_comb begin
      all_fin = 1'b1;
      for (int i = 0; i < ProgramDepth; i++)
         if (PIdxW'(i) < count_ff[PIdxW-1:0] || count_ff[PIdxW]) begin
            if (i < int'(count_ff) && stage_ff[i] != ST_FINISHED) all_fin = 1'b0;
         end
   end

   // finished is judged after the issue write lands
   logic all_fin_next;
   always_comb begin
      all_fin_next = all_fin && !(first_ok_ff && free_ok);
   end

   logic req_ok;
   assign req_ok = (cycle_ff == 16'd0) && (count_ff < (PIdxW+1)'(ProgramDepth)) &&
                   (req_data.opcode <= OP_DIV);

   // next state
   always_comb begin
      state_in = state_ff;
      ptr_in = ptr_ff;
      case (state_ff)
         SEQ_IDLE: if (take) begin
            ptr_in = '0;
            state_in = (req_data.func && !finished_ff) ? SEQ_EXEC : SEQ_STATUS;
         end
         SEQ_EXEC: if (end_pend_ff) begin
            ptr_in = ptr_ff + 1'b1;
         end else if (at_end) begin
            ptr_in = '0; state_in = SEQ_RUN;
         end else if (!begin_end) ptr_in = ptr_ff + 1'b1;
         SEQ_RUN: if (at_end) begin
            ptr_in = '0; state_in = SEQ_WB;
         end else ptr_in = ptr_ff + 1'b1;
         SEQ_WB: if (at_end) state_in = SEQ_ISSUE;
            else ptr_in = ptr_ff + 1'b1;
         SEQ_ISSUE: state_in = SEQ_STATUS;
         SEQ_STATUS: state_in = SEQ_IDLE;
         default: state_in = SEQ_IDLE;
      endcase
   end

   // outputs
   rsp_type rsp_in;
   logic strobe_in;
   always_comb begin
      rsp_in = '0;
      strobe_in = 1'b0;
      rsp_in.cycle = cycle_ff;
      case (state_ff)
         SEQ_EXEC: if (end_pend_ff) begin
            strobe_in = 1'b1; rsp_in.kind = KIND_END; rsp_in.instr_index = 3'(pi);
         end else if (!at_end && snap_ff[pi] == ST_WAITING && !cur_blocked) begin
            if (!began_ff[pi]) begin
               strobe_in = 1'b1; rsp_in.kind = KIND_BEGIN; rsp_in.instr_index = 3'(pi);
            end else if (rem_dec == 8'd0) begin
               strobe_in = 1'b1; rsp_in.kind = KIND_END; rsp_in.instr_index = 3'(pi);
            end
         end
         SEQ_RUN: if (!at_end && snap_ff[pi] == ST_RUNNING && rem_dec == 8'd0) begin
            strobe_in = 1'b1; rsp_in.kind = KIND_END; rsp_in.instr_index = 3'(pi);
         end
         SEQ_WB: if (!at_end && snap_ff[pi] == ST_DONE_EXEC) begin
            strobe_in = 1'b1; rsp_in.kind = KIND_WB; rsp_in.instr_index = 3'(pi);
         end
         SEQ_ISSUE: if (first_ok_ff && free_ok) begin
            strobe_in = 1'b1; rsp_in.kind = KIND_ISSUE;
            rsp_in.instr_index = 3'(first_ff);
         end
         SEQ_STATUS: begin
            strobe_in = 1'b1; rsp_in.kind = KIND_STATUS;
            rsp_in.accepted = acc_ff; rsp_in.all_done = finished_ff; rsp_in.last = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_data <= rsp_in;
      if (reset) begin
         rsp_strobe <= 1'b0;
         state_ff <= SEQ_IDLE;
         ptr_ff <= '0;
         count_ff <= '0;
         cycle_ff <= '0;
         finished_ff <= 1'b0;
         acc_ff <= 1'b0;
         end_pend_ff <= 1'b0;
         first_ok_ff <= 1'b0;
         first_ff <= '0;
         began_ff <= '0;
         sbusy_ff <= '0;
         wa_on_ff <= '0;
         wb_on_ff <= '0;
         rpend_ff <= '0;
         lat_ff[0] <= 8'd2; lat_ff[1] <= 8'd2; lat_ff[2] <= 8'd10; lat_ff[3] <= 8'd40;
         for (int i = 0; i < ProgramDepth; i++) stage_ff[i] <= ST_UNISSUED;
      end else begin
         rsp_strobe <= strobe_in;
         state_ff <= state_in;
         ptr_ff <= ptr_in;
         if (csr_valid && csr_ready) lat_ff[csr_index] <= csr_wdata;
         case (state_ff)
            SEQ_IDLE: if (take) begin
               acc_ff <= !req_data.func && req_ok;
               if (!req_data.func) begin
                  if (req_ok) begin
                     op_ff[count_ff[PIdxW-1:0]] <= req_data.opcode;
                     dst_ff[count_ff[PIdxW-1:0]] <= req_data.dest_reg;
                     sa_ff[count_ff[PIdxW-1:0]] <= req_data.src_a_reg;
                     sb_ff[count_ff[PIdxW-1:0]] <= req_data.src_b_reg;
                     count_ff <= count_ff + 1'b1;
                  end
               end else if (!finished_ff) begin
                  if (cycle_ff != 16'hFFFF) cycle_ff <= cycle_ff + 16'd1;
                  first_ok_ff <= first_ok_c;
                  first_ff <= first_c;
                  for (int i = 0; i < ProgramDepth; i++) snap_ff[i] <= stage_ff[i];
               end
            end
            SEQ_EXEC: if (end_pend_ff) begin
               end_pend_ff <= 1'b0;
            end else if (!at_end && snap_ff[pi] == ST_WAITING && !cur_blocked) begin
               rem_ff[pi] <= rem_dec;
               stage_ff[pi] <= (rem_dec == 8'd0) ? ST_DONE_EXEC : ST_RUNNING;
               if (!began_ff[pi]) begin
                  began_ff[pi] <= 1'b1;
                  if (rem_dec == 8'd0) end_pend_ff <= 1'b1;
               end
            end
            SEQ_RUN: if (!at_end && snap_ff[pi] == ST_RUNNING) begin
               rem_ff[pi] <= rem_dec;
               if (rem_dec == 8'd0) stage_ff[pi] <= ST_DONE_EXEC;
            end
            SEQ_WB: if (!at_end && snap_ff[pi] == ST_DONE_EXEC) begin
               stage_ff[pi] <= ST_FINISHED;
               sbusy_ff[cur_tag] <= 1'b0;
               for (int j = 0; j < FpRegs; j++)
                  if (rpend_ff[j] && rstat_ff[j] == cur_tag) rpend_ff[j] <= 1'b0;
               for (int j = 0; j < AllStations; j++) begin
                  if (wa_on_ff[j] && wa_ff[j] == cur_tag) wa_on_ff[j] <= 1'b0;
                  if (wb_on_ff[j] && wb_ff[j] == cur_tag) wb_on_ff[j] <= 1'b0;
               end
            end
            SEQ_ISSUE: begin
               if (first_ok_ff && free_ok) begin
                  sbusy_ff[free_s] <= 1'b1;
                  tag_ff[first_ff[PIdxW-1:0]] <= free_s;
                  rem_ff[first_ff[PIdxW-1:0]] <= ilat;
                  stage_ff[first_ff[PIdxW-1:0]] <= ST_WAITING;
                  if (iop != OP_LOAD) begin
                     wa_on_ff[free_s] <= rpend_ff[sa_ff[first_ff[PIdxW-1:0]]];
                     wa_ff[free_s] <= rstat_ff[sa_ff[first_ff[PIdxW-1:0]]];
                     wb_on_ff[free_s] <= rpend_ff[sb_ff[first_ff[PIdxW-1:0]]];
                     wb_ff[free_s] <= rstat_ff[sb_ff[first_ff[PIdxW-1:0]]];
                  end else begin
                     wa_on_ff[free_s] <= 1'b0;
                     wb_on_ff[free_s] <= 1'b0;
                  end
                  rpend_ff[dst_ff[first_ff[PIdxW-1:0]]] <= 1'b1;
                  rstat_ff[dst_ff[first_ff[PIdxW-1:0]]] <= free_s;
               end
            end
            SEQ_STATUS: ;
            default: ;
         endcase
         if (state_ff == SEQ_ISSUE) finished_ff <= all_fin_next;
      end
   end

   // the status flag must show before status beat; it is registered in the issue state
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last |-> rsp_data.kind == KIND_STATUS)
      else $error("last beat is not status");
   assert property (@(posedge clock) disable iff (reset)
      take |=> busy_i)
      else $error("busy did not rise");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == SEQ_STATUS |=> rsp_strobe && rsp_data.last)
      else $error("status beat missing");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PIdxW+1)'(ProgramDepth))
      else $error("program count overflow");

endmodule
